[src/csi_pkg.sv]
package csi_pkg;

  localparam int COORD_BITS = 24;
  localparam int RAD_BITS   = COORD_BITS - 1;
  localparam int R2_BITS    = 2 * RAD_BITS;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int SUM_BITS   = PROD_BITS + 3;
  localparam int MAG_BITS   = SUM_BITS - 1;
  localparam int HALF_BITS  = (MAG_BITS + 1) / 2;
  localparam int PART_BITS  = 2 * HALF_BITS;
  localparam int TOT_BITS   = 2 * PART_BITS + 1;

  typedef enum logic [1:0] {
    ROOT_NONE  = 2'd0,
    ROOT_ENTRY = 2'd1,
    ROOT_EXIT  = 2'd2
  } root_t;

  typedef struct packed {
    logic a_pos;
    logic b_le0;
    logic c_ge0;
    logic c_le0;
    logic ab_ge0;
    logic e_le0;
    logic e_ge0;
  } flags_t;

  typedef struct packed {
    logic ce;
    logic vld;
  } pipe_t;

endpackage

[src/csi_prod.sv]
module csi_prod (
  input  logic clk,
  input  logic rst,
  input  csi_pkg::pipe_t ctl,
  input  logic signed [csi_pkg::COORD_BITS-1:0] cen [3],
  input  logic signed [csi_pkg::COORD_BITS-1:0] st [3],
  input  logic signed [csi_pkg::COORD_BITS-1:0] en [3],
  input  logic [csi_pkg::RAD_BITS-1:0] rad_in,
  output logic vld2,
  output logic signed [csi_pkg::PROD_BITS-1:0] yy [3],
  output logic signed [csi_pkg::PROD_BITS-1:0] xy [3],
  output logic signed [csi_pkg::PROD_BITS-1:0] xx [3],
  output logic signed [csi_pkg::PROD_BITS-1:0] zz [3],
  output logic [csi_pkg::R2_BITS-1:0] r2
);
  import csi_pkg::*;

  logic signed [DIFF_BITS-1:0] x [3];
  logic signed [DIFF_BITS-1:0] y [3];
  logic signed [DIFF_BITS-1:0] z [3];
  logic [RAD_BITS-1:0] rad;
  logic vld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else if (ctl.ce) begin
      vld1 <= ctl.vld;
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ce) begin
      for (int k = 0; k < 3; k++) begin
        x[k] <= DIFF_BITS'(st[k]) - DIFF_BITS'(cen[k]);
        y[k] <= DIFF_BITS'(en[k]) - DIFF_BITS'(st[k]);
        z[k] <= DIFF_BITS'(en[k]) - DIFF_BITS'(cen[k]);
      end
      rad <= rad_in;
      for (int k = 0; k < 3; k++) begin
        yy[k] <= y[k] * y[k];
        xy[k] <= x[k] * y[k];
        xx[k] <= x[k] * x[k];
        zz[k] <= z[k] * z[k];
      end
      r2 <= R2_BITS'(rad) * R2_BITS'(rad);
    end
  end
endmodule

[src/csi_disc.sv]
module csi_disc (
  input  logic clk,
  input  logic rst,
  input  csi_pkg::pipe_t ctl,
  input  logic [csi_pkg::MAG_BITS-1:0] mag_a,
  input  logic [csi_pkg::MAG_BITS-1:0] mag_b,
  input  logic [csi_pkg::MAG_BITS-1:0] mag_c,
  input  csi_pkg::flags_t flags_in,
  output logic vld_out,
  output logic disc_ok,
  output csi_pkg::flags_t flags_out
);
  import csi_pkg::*;

  logic [PART_BITS-1:0] bhh, bhl, bll, ahh, ahl, alh, all;
  logic [TOT_BITS-1:0] bb, ac;
  flags_t f4, f5;
  logic v4, v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      vld_out <= 1'b0;
    end else if (ctl.ce) begin
      v4 <= ctl.vld;
      v5 <= v4;
      vld_out <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ce) begin
      bhh <= PART_BITS'(mag_b[MAG_BITS-1:HALF_BITS]) * PART_BITS'(mag_b[MAG_BITS-1:HALF_BITS]);
      bhl <= PART_BITS'(mag_b[MAG_BITS-1:HALF_BITS]) * PART_BITS'(mag_b[HALF_BITS-1:0]);
      bll <= PART_BITS'(mag_b[HALF_BITS-1:0]) * PART_BITS'(mag_b[HALF_BITS-1:0]);
      ahh <= PART_BITS'(mag_a[MAG_BITS-1:HALF_BITS]) * PART_BITS'(mag_c[MAG_BITS-1:HALF_BITS]);
      ahl <= PART_BITS'(mag_a[MAG_BITS-1:HALF_BITS]) * PART_BITS'(mag_c[HALF_BITS-1:0]);
      alh <= PART_BITS'(mag_a[HALF_BITS-1:0]) * PART_BITS'(mag_c[MAG_BITS-1:HALF_BITS]);
      all <= PART_BITS'(mag_a[HALF_BITS-1:0]) * PART_BITS'(mag_c[HALF_BITS-1:0]);
      f4 <= flags_in;
      bb <= (TOT_BITS'(bhh) << (2 * HALF_BITS)) + (TOT_BITS'(bhl) << (HALF_BITS + 1))
            + TOT_BITS'(bll);
      ac <= (TOT_BITS'(ahh) << (2 * HALF_BITS))
            + ((TOT_BITS'(ahl) + TOT_BITS'(alh)) << HALF_BITS) + TOT_BITS'(all);
      f5 <= f4;
      disc_ok <= f5.c_le0 || (bb >= ac);
      flags_out <= f5;
    end
  end
endmodule

[src/circle_segment_intersect_core.sv]
// Throughput: one item per cycle unless the output stalls; the 52x52 discriminant products are split
// into 26x26 partial products over three pipeline stages.
// A stalled output holds the whole pipeline.
// Reset (rst, synchronous) clears all stage valid bits.
module circle_segment_intersect_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [csi_pkg::COORD_BITS-1:0] center_x,
  input  logic signed [csi_pkg::COORD_BITS-1:0] ctr_y,
  input  logic signed [csi_pkg::COORD_BITS-1:0] center_z,
  input  logic [csi_pkg::RAD_BITS-1:0] radius,
  input  logic signed [csi_pkg::COORD_BITS-1:0] start_x,
  input  logic signed [csi_pkg::COORD_BITS-1:0] start_y,
  input  logic signed [csi_pkg::COORD_BITS-1:0] start_z,
  input  logic signed [csi_pkg::COORD_BITS-1:0] end_x,
  input  logic signed [csi_pkg::COORD_BITS-1:0] end_y,
  input  logic signed [csi_pkg::COORD_BITS-1:0] end_z,
  output logic out_valid,
  input  logic out_ready,
  output logic hit,
  output logic [1:0] hit_root
);
  import csi_pkg::*;

  logic ce;
  pipe_t ctl_in, ctl3;
  logic signed [COORD_BITS-1:0] cen [3];
  logic signed [COORD_BITS-1:0] st [3];
  logic signed [COORD_BITS-1:0] en [3];
  logic signed [PROD_BITS-1:0] yy [3];
  logic signed [PROD_BITS-1:0] xy [3];
  logic signed [PROD_BITS-1:0] xx [3];
  logic signed [PROD_BITS-1:0] zz [3];
  logic [R2_BITS-1:0] r2;
  logic vld2, vld3;
  logic signed [SUM_BITS-1:0] a, b, c, e, ab;
  logic [MAG_BITS-1:0] mag_a, mag_b, mag_c;
  flags_t flags3, flags_o;
  logic disc_ok;
  root_t root;

  assign ce = !out_valid || out_ready;
  assign in_ready = ce;
  assign ctl_in = '{ce: ce, vld: in_valid};
  assign ctl3 = '{ce: ce, vld: vld3};

  assign cen = '{center_x, ctr_y, center_z};
  assign st  = '{start_x, start_y, start_z};
  assign en  = '{end_x, end_y, end_z};

  csi_prod u_prod (
    .clk(clk), .rst(rst), .ctl(ctl_in), .cen(cen), .st(st), .en(en), .rad_in(radius),
    .vld2(vld2), .yy(yy), .xy(xy), .xx(xx), .zz(zz), .r2(r2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (ce) begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a <= SUM_BITS'(yy[0]) + SUM_BITS'(yy[1]) + SUM_BITS'(yy[2]);
      b <= SUM_BITS'(xy[0]) + SUM_BITS'(xy[1]) + SUM_BITS'(xy[2]);
      c <= SUM_BITS'(xx[0]) + SUM_BITS'(xx[1]) + SUM_BITS'(xx[2])
           - SUM_BITS'($signed({1'b0, r2}));
      e <= SUM_BITS'(zz[0]) + SUM_BITS'(zz[1]) + SUM_BITS'(zz[2])
           - SUM_BITS'($signed({1'b0, r2}));
      ab <= SUM_BITS'(yy[0]) + SUM_BITS'(yy[1]) + SUM_BITS'(yy[2])
            + SUM_BITS'(xy[0]) + SUM_BITS'(xy[1]) + SUM_BITS'(xy[2]);
    end
  end

  always_comb begin
    logic signed [SUM_BITS-1:0] nb, nc;
    nb = -b;
    nc = -c;
    mag_a = a[MAG_BITS-1:0];
    mag_b = b[SUM_BITS-1] ? nb[MAG_BITS-1:0] : b[MAG_BITS-1:0];
    mag_c = c[SUM_BITS-1] ? nc[MAG_BITS-1:0] : c[MAG_BITS-1:0];
    flags3.a_pos  = !a[SUM_BITS-1] && (a != '0);
    flags3.b_le0  = b[SUM_BITS-1] || (b == '0);
    flags3.c_ge0  = !c[SUM_BITS-1];
    flags3.c_le0  = c[SUM_BITS-1] || (c == '0);
    flags3.ab_ge0 = !ab[SUM_BITS-1];
    flags3.e_le0  = e[SUM_BITS-1] || (e == '0);
    flags3.e_ge0  = !e[SUM_BITS-1];
  end

  csi_disc u_disc (
    .clk(clk), .rst(rst), .ctl(ctl3), .mag_a(mag_a), .mag_b(mag_b), .mag_c(mag_c),
    .flags_in(flags3), .vld_out(out_valid), .disc_ok(disc_ok), .flags_out(flags_o)
  );

  always_comb begin
    root = ROOT_NONE;
    if (flags_o.a_pos && disc_ok) begin
      if (flags_o.b_le0 && flags_o.c_ge0 && (flags_o.ab_ge0 || flags_o.e_le0)) begin
        root = ROOT_ENTRY;
      end else if ((flags_o.b_le0 || flags_o.c_le0) && flags_o.ab_ge0 && flags_o.e_ge0) begin
        root = ROOT_EXIT;
      end
    end
  end

  assign hit = (root != ROOT_NONE);
  assign hit_root = root;
endmodule

[tb/tb_circle_segment_intersect_core.sv]
`timescale 1ns / 1ps

module tb_circle_segment_intersect_core;
  import csi_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int RW = RAD_BITS;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [RW-1:0] RMAX = {RW{1'b1}};
  localparam int ONE = 256;

  typedef struct {
    logic signed [CW-1:0] cx, cy, cz;
    logic [RW-1:0] rad;
    logic signed [CW-1:0] sx, sy, sz;
    logic signed [CW-1:0] ex, ey, ez;
  } query_t;

  typedef struct {
    query_t q;
    bit typed;
    root_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [CW-1:0] center_x, ctr_y, center_z;
  logic [RW-1:0] radius;
  logic signed [CW-1:0] start_x, start_y, start_z, end_x, end_y, end_z;
  logic hit;
  logic [1:0] hit_root;

  root_t pending_roots[$];
  int errors = 0;
  bit gaps_on = 1'b1;
  int stall_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  circle_segment_intersect_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .center_x(center_x), .ctr_y(ctr_y), .center_z(center_z),
    .radius(radius),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .end_x(end_x), .end_y(end_y), .end_z(end_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .hit_root(hit_root)
  );

  function automatic root_t predict_root(query_t q);
    logic signed [191:0] x0, x1, x2, y0, y1, y2, z0, z1, z2;
    logic signed [191:0] rr, r2, a, b, c, e, ab, disc;
    root_t r;
    x0 = q.sx - q.cx; x1 = q.sy - q.cy; x2 = q.sz - q.cz;
    y0 = q.ex - q.sx; y1 = q.ey - q.sy; y2 = q.ez - q.sz;
    z0 = q.ex - q.cx; z1 = q.ey - q.cy; z2 = q.ez - q.cz;
    rr = q.rad;
    r2 = rr * rr;
    a = y0 * y0 + y1 * y1 + y2 * y2;
    b = x0 * y0 + x1 * y1 + x2 * y2;
    c = x0 * x0 + x1 * x1 + x2 * x2 - r2;
    e = z0 * z0 + z1 * z1 + z2 * z2 - r2;
    ab = a + b;
    disc = b * b - a * c;
    r = ROOT_NONE;
    if (a > 0 && disc >= 0) begin
      if (b <= 0 && c >= 0 && (ab >= 0 || e <= 0))
        r = ROOT_ENTRY;
      else if ((b <= 0 || c <= 0) && ab >= 0 && e >= 0)
        r = ROOT_EXIT;
    end
    return r;
  endfunction

  function automatic query_t make_query(int cx, int cy, int cz, int rad,
                                        int sx, int sy, int sz,
                                        int ex, int ey, int ez);
    query_t q;
    q.cx = CW'(cx); q.cy = CW'(cy); q.cz = CW'(cz); q.rad = RW'(rad);
    q.sx = CW'(sx); q.sy = CW'(sy); q.sz = CW'(sz);
    q.ex = CW'(ex); q.ey = CW'(ey); q.ez = CW'(ez);
    return q;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    return CW'($urandom);
  endfunction

  function automatic int near(int base, int span);
    return base + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int cx, cy, cz, rad, span, pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      q.cx = rand_coord(); q.cy = rand_coord(); q.cz = rand_coord();
      q.rad = RW'($urandom);
      q.sx = rand_coord(); q.sy = rand_coord(); q.sz = rand_coord();
      q.ex = rand_coord(); q.ey = rand_coord(); q.ez = rand_coord();
      if (pick == 1) begin
        q.ex = q.sx; q.ey = q.sy; q.ez = q.sz;
      end
    end else begin
      cx = near(0, 1 << 20); cy = near(0, 1 << 20); cz = near(0, 1 << 20);
      rad = $urandom_range(0, 1 << 17);
      span = 2 * rad + 4;
      q = make_query(cx, cy, cz, rad,
                     near(cx, span), near(cy, span), near(cz, span),
                     near(cx, span), near(cy, span), near(cz, span));
      if (pick == 9) begin
        q.rad = RMAX - RW'($urandom_range(0, 3));
        q.sx = CMIN; q.ex = CMAX;
      end
    end
    return q;
  endfunction

  task automatic send_query(query_t q, bit typed, root_t want);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    center_x <= q.cx; ctr_y <= q.cy; center_z <= q.cz;
    radius <= q.rad;
    start_x <= q.sx; start_y <= q.sy; start_z <= q.sz;
    end_x <= q.ex; end_y <= q.ey; end_z <= q.ez;
    do @(posedge clk); while (!in_ready);
    pending_roots.push_back(typed ? want : predict_root(q));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    root_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected item hit=%0d hit_root=%0d", $time, hit, hit_root);
        errors++;
      end else begin
        want = pending_roots.pop_front();
        if (hit !== (want != ROOT_NONE)) begin
          $display("%0t: hit expected %0d actual %0d", $time, want != ROOT_NONE, hit);
          errors++;
        end
        if (hit_root !== want) begin
          $display("%0t: hit_root expected %0d actual %0d", $time, want, hit_root);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    query_t q;
    rst = 1'b1;
    in_valid = 1'b0;
    center_x = '0; ctr_y = '0; center_z = '0; radius = '0;
    start_x = '0; start_y = '0; start_z = '0;
    end_x = '0; end_y = '0; end_z = '0;

    rows.push_back('{make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, ROOT_NONE});
    rows.push_back('{make_query(0, 0, 0, ONE, -2*ONE, 0, 0, 2*ONE, 0, 0), 1'b1, ROOT_ENTRY});
    rows.push_back('{make_query(0, 0, 0, ONE, 0, 0, 0, 2*ONE, 0, 0), 1'b1, ROOT_EXIT});
    rows.push_back('{make_query(0, 0, 0, ONE, -64, 0, 0, 64, 0, 0), 1'b1, ROOT_NONE});
    rows.push_back('{make_query(0, 0, 0, ONE, -2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0),
                     1'b1, ROOT_NONE});
    rows.push_back('{make_query(0, 0, 0, ONE, -2*ONE, ONE, 0, 2*ONE, ONE, 0),
                     1'b1, ROOT_ENTRY});
    rows.push_back('{make_query(0, 0, 0, ONE, 2*ONE, 0, 0, 4*ONE, 0, 0), 1'b1, ROOT_NONE});
    rows.push_back('{make_query(0, 0, 0, ONE, -4*ONE, 0, 0, -2*ONE, 0, 0), 1'b1, ROOT_NONE});
    rows.push_back('{make_query(0, 0, 0, ONE, -2*ONE, 0, 0, -ONE, 0, 0), 1'b0, ROOT_NONE});
    rows.push_back('{make_query(0, 0, 0, 0, -ONE, 0, 0, ONE, 0, 0), 1'b0, ROOT_NONE});
    rows.push_back('{make_query(5, -7, 3, ONE, 5, -7, 3 - ONE, 5, -7, 3 + ONE),
                     1'b0, ROOT_NONE});
    rows.push_back('{make_query(CMAX, CMAX, CMAX, RMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX),
                     1'b0, ROOT_NONE});
    rows.push_back('{make_query(CMIN, CMIN, CMIN, 0, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN),
                     1'b0, ROOT_NONE});
    rows.push_back('{make_query(CMIN, CMAX, CMIN, RMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN),
                     1'b0, ROOT_NONE});
    rows.push_back('{make_query(0, 0, 0, RMAX, CMIN, 0, 0, CMAX, 0, 0), 1'b0, ROOT_NONE});
    rows.push_back('{make_query(CMAX, 0, 0, RMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX),
                     1'b1, ROOT_NONE});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_query(rows[i].q, rows[i].typed, rows[i].want);

    in_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);

    for (int n = 0; n < 800; n++) begin
      if (n == 650) gaps_on = 1'b0;
      q = rand_query();
      send_query(q, 1'b0, ROOT_NONE);
    end
    in_valid <= 1'b0;

    while (pending_roots.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
src/csi_pkg.sv
src/csi_prod.sv
src/csi_disc.sv
src/circle_segment_intersect_core.sv
tb/tb_circle_segment_intersect_core.sv
